/* src/wms_pkg.sv */
// ----------------------------------------------------------------------------
// wms_pkg: shared types and constants for the wheel move sequencer
// Holds the command and move-kind codes, the item, entry and result records,
// and the reset values of the configuration registers.
// ----------------------------------------------------------------------------
package wms_pkg;

  localparam int QUEUE_DEPTH_DEF = 32;

  localparam logic [7:0] TOLERANCE_RESET = 8'd1;
  localparam logic [9:0] CLAMP_RESET     = 10'd50;

  // configuration register indexes
  localparam logic CFG_TOLERANCE = 1'b0;
  localparam logic CFG_CLAMP     = 1'b1;

  typedef enum logic [2:0] {
    CMD_STRAIGHT = 3'd0,
    CMD_ROTATE   = 3'd1,
    CMD_TURN     = 3'd2,
    CMD_SAMPLE   = 3'd3,
    CMD_CONTROL  = 3'd4,
    CMD_OUTPUT   = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_STRAIGHT = 2'd0,
    KIND_ROTATE   = 2'd1,
    KIND_TURN     = 2'd2
  } kind_e;

  typedef struct packed {
    cmd_e               command;
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic signed [15:0] move_amount;
    logic signed [7:0]  move_speed;
  } item_t;

  // one queued move, kept as given and expanded when loaded
  typedef struct packed {
    kind_e              kind;
    logic signed [15:0] amount;
    logic signed [7:0]  speed;
  } entry_t;

  typedef struct packed {
    logic full;
    logic avail;
  } queue_status_t;

  typedef struct packed {
    logic signed [8:0] left_speed;
    logic signed [8:0] right_speed;
    logic              motor_write;
    logic              mission_done;
    logic              queue_full;
    logic              last;
  } result_t;

endpackage

/* src/wms_queue.sv */
// ----------------------------------------------------------------------------
// wms_queue: move queue storage
// Append-only memory of moves with a fill count and a read pointer. The entry
// at the read pointer is prefetched into a register, with write bypass.
// ----------------------------------------------------------------------------
module wms_queue #(
  parameter int QUEUE_DEPTH = wms_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  wms_pkg::entry_t        push_entry,
  input  logic                   pop,
  output wms_pkg::queue_status_t status,
  output wms_pkg::entry_t        head
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  wms_pkg::entry_t mem [QUEUE_DEPTH];

  logic [CW-1:0] count;
  logic [CW-1:0] rd_ptr;
  logic [CW-1:0] rd_ptr_next;
  logic          do_push;

  assign status.full  = (count == CW'(QUEUE_DEPTH));
  assign status.avail = (rd_ptr != count);
  assign do_push      = push && !status.full;
  assign rd_ptr_next  = (pop && status.avail) ? rd_ptr + CW'(1) : rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      rd_ptr <= '0;
    end else begin
      if (do_push) begin
        count <= count + CW'(1);
      end
      rd_ptr <= rd_ptr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[count[AW-1:0]] <= push_entry;
    end
  end

  // prefetch the entry the pointer will address next cycle
  always_ff @(posedge clk) begin
    if (do_push && (count == rd_ptr_next)) begin
      head <= push_entry;
    end else begin
      head <= mem[rd_ptr_next[AW-1:0]];
    end
  end

endmodule

/* src/wms_core.sv */
// ----------------------------------------------------------------------------
// wms_core: position controller datapath
// Holds targets, positions, speeds and mission flags, and turns one command
// into one or two results combinationally.
// ----------------------------------------------------------------------------
module wms_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fire,
  input  wms_pkg::item_t         item,
  input  logic [7:0]             tolerance,
  input  logic [9:0]             clamp,
  input  wms_pkg::queue_status_t qstat,
  input  wms_pkg::entry_t        head,
  output logic                   push,
  output wms_pkg::entry_t        push_entry,
  output logic                   pop,
  output wms_pkg::result_t       res0,
  output wms_pkg::result_t       res1,
  output logic                   two
);

  localparam logic [9:0] RECIP_5     = 10'd205;
  localparam int         RECIP_SHIFT = 10;

  logic signed [31:0] target_left,    target_left_next;
  logic signed [31:0] target_right,   target_right_next;
  logic signed [31:0] position_left,  position_left_next;
  logic signed [31:0] position_right, position_right_next;
  logic signed [8:0]  speed_left,     speed_left_next;
  logic signed [8:0]  speed_right,    speed_right_next;
  logic               finished,       finished_next;
  logic               position_seen,  position_seen_next;

  logic signed [31:0] tgt_eff_l, tgt_eff_r;
  logic signed [32:0] arr_err_l, arr_err_r;
  logic signed [32:0] ctl_err_l, ctl_err_r;
  logic signed [32:0] tol_pos, tol_neg;
  logic               arrived;

  logic signed [8:0]  spd9, ent_p, ent_np;
  logic signed [16:0] amt17, amt17_neg;
  logic signed [31:0] delta_l, delta_r;
  logic signed [8:0]  ent_spd_l, ent_spd_r;

  // clamp the error, divide by five toward zero via reciprocal multiply
  function automatic logic signed [8:0] ctl_speed(input logic signed [32:0] err,
                                                  input logic [9:0] lim);
    logic signed [32:0] c;
    logic signed [32:0] mag33;
    logic [9:0]         mag;
    logic [19:0]        prod;
    logic [8:0]         quo;
    c     = $signed({23'd0, lim});
    mag33 = (err < 0) ? -err : err;
    if ((err > c) || (err < -c)) begin
      mag = lim;
    end else begin
      mag = mag33[9:0];
    end
    prod = mag * RECIP_5;
    quo  = prod[RECIP_SHIFT +: 9];
    return (err < 0) ? -$signed(quo) : $signed(quo);
  endfunction

  // expand the head entry into deltas and speeds
  always_comb begin
    spd9      = {head.speed[7], head.speed};
    ent_p     = (head.amount > 0) ? spd9 : -spd9;
    ent_np    = -ent_p;
    amt17     = {head.amount[15], head.amount};
    amt17_neg = -amt17;
    delta_l   = {{16{head.amount[15]}}, head.amount};
    ent_spd_l = ent_p;
    case (head.kind)
      wms_pkg::KIND_STRAIGHT: begin
        delta_r   = delta_l;
        ent_spd_r = ent_p;
      end
      wms_pkg::KIND_ROTATE: begin
        delta_r   = {{15{amt17_neg[16]}}, amt17_neg};
        ent_spd_r = ent_np;
      end
      default: begin
        delta_r   = '0;
        ent_spd_r = '0;
      end
    endcase
  end

  // errors: arrival test uses the sampled counts, control uses held state
  always_comb begin
    tgt_eff_l = position_seen ? target_left  : item.left_count;
    tgt_eff_r = position_seen ? target_right : item.right_count;
    arr_err_l = {tgt_eff_l[31], tgt_eff_l} - {item.left_count[31], item.left_count};
    arr_err_r = {tgt_eff_r[31], tgt_eff_r} - {item.right_count[31], item.right_count};
    ctl_err_l = {target_left[31], target_left} - {position_left[31], position_left};
    ctl_err_r = {target_right[31], target_right} - {position_right[31], position_right};
    tol_pos   = $signed({25'd0, tolerance});
    tol_neg   = -tol_pos;
    arrived   = (arr_err_l <= tol_pos) && (arr_err_l >= tol_neg) &&
                (arr_err_r <= tol_pos) && (arr_err_r >= tol_neg);
  end

  always_comb begin
    target_left_next    = target_left;
    target_right_next   = target_right;
    position_left_next  = position_left;
    position_right_next = position_right;
    speed_left_next     = speed_left;
    speed_right_next    = speed_right;
    finished_next       = finished;
    position_seen_next  = position_seen;
    push                = 1'b0;
    pop                 = 1'b0;
    two                 = 1'b0;
    push_entry.kind     = wms_pkg::kind_e'(item.command[1:0]);
    push_entry.amount   = item.move_amount;
    push_entry.speed    = item.move_speed;

    res0.left_speed   = speed_left;
    res0.right_speed  = speed_right;
    res0.motor_write  = 1'b0;
    res0.mission_done = 1'b0;
    res0.queue_full   = 1'b0;
    res0.last         = 1'b1;
    res1              = res0;

    case (item.command)
      wms_pkg::CMD_STRAIGHT, wms_pkg::CMD_ROTATE, wms_pkg::CMD_TURN: begin
        push            = fire;
        res0.queue_full = qstat.full;
      end
      wms_pkg::CMD_SAMPLE: begin
        position_left_next  = item.left_count;
        position_right_next = item.right_count;
        position_seen_next  = 1'b1;
        target_left_next    = tgt_eff_l;
        target_right_next   = tgt_eff_r;
        if (arrived) begin
          speed_left_next  = '0;
          speed_right_next = '0;
          finished_next    = 1'b1;
          res0.left_speed  = '0;
          res0.right_speed = '0;
          res0.motor_write = 1'b1;
          if (qstat.avail) begin
            target_left_next  = item.left_count + delta_l;
            target_right_next = item.right_count + delta_r;
            speed_left_next   = ent_spd_l;
            speed_right_next  = ent_spd_r;
            finished_next     = 1'b0;
            pop               = fire;
            two               = 1'b1;
            res0.last         = 1'b0;
            res1.left_speed   = ent_spd_l;
            res1.right_speed  = ent_spd_r;
            res1.motor_write  = 1'b1;
            res1.last         = 1'b1;
          end
        end
      end
      wms_pkg::CMD_CONTROL: begin
        if (!finished) begin
          speed_left_next  = ctl_speed(ctl_err_l, clamp);
          speed_right_next = ctl_speed(ctl_err_r, clamp);
        end
        res0.left_speed  = speed_left_next;
        res0.right_speed = speed_right_next;
      end
      wms_pkg::CMD_OUTPUT: begin
        res0.motor_write = 1'b1;
      end
      default: begin
      end
    endcase

    res0.mission_done = finished_next;
    res1.mission_done = finished_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_left    <= '0;
      target_right   <= '0;
      position_left  <= '0;
      position_right <= '0;
      speed_left     <= '0;
      speed_right    <= '0;
      finished       <= 1'b0;
      position_seen  <= 1'b0;
    end else if (fire) begin
      target_left    <= target_left_next;
      target_right   <= target_right_next;
      position_left  <= position_left_next;
      position_right <= position_right_next;
      speed_left     <= speed_left_next;
      speed_right    <= speed_right_next;
      finished       <= finished_next;
      position_seen  <= position_seen_next;
    end
  end

endmodule

/* src/wms_outbuf.sv */
// ----------------------------------------------------------------------------
// wms_outbuf: two-slot result buffer
// Takes one or two results per item and hands them out one beat at a time.
// ----------------------------------------------------------------------------
module wms_outbuf (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  logic             two,
  input  wms_pkg::result_t res0,
  input  wms_pkg::result_t res1,
  input  logic             out_ready,
  output logic             out_valid,
  output wms_pkg::result_t out_res,
  output logic             can_load
);

  wms_pkg::result_t slot0, slot1;
  logic [1:0]       count;
  logic             pop;

  assign out_valid = (count != 2'd0);
  assign out_res   = slot0;
  assign pop       = out_valid && out_ready;
  assign can_load  = (count == 2'd0) || ((count == 2'd1) && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (load) begin
      count <= two ? 2'd2 : 2'd1;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot0 <= res0;
      slot1 <= res1;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

endmodule

/* src/wheel_move_sequencer.sv */
// ----------------------------------------------------------------------------
// wheel_move_sequencer: two-wheel encoder position controller
// Queues straight, rotate and pivot-turn moves, checks arrival on encoder
// samples, loads the next move, and computes clamped proportional speeds.
//
//   channel  dir  signals                       beat contents
//   s_*      in   tvalid tready tdata tuser     one command with its operands
//   m_*      out  tvalid tready tdata tuser     one result, tlast ends the item
//                 tlast
//   cfg_*    in   wen addr wdata                register write, no read-back
//
// An accepted beat is held in the input register, then all of its work is done
// as it is loaded into a two-slot result buffer; one item per cycle is
// sustained while results are taken every cycle. An encoder sample that loads
// a move gives two results and holds the next item until the buffer has room.
// rst is synchronous; the move queue is not cleared, only its counts are.
// Stalls on m_tready back up through the buffer into s_tready.
// ----------------------------------------------------------------------------
module wheel_move_sequencer #(
  parameter int QUEUE_DEPTH = wms_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // left_count[31:0], right_count[63:32], move_amount[79:64], move_speed[87:80]
  input  logic [87:0] s_tdata,
  // command[2:0]
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // left_speed[8:0], right_speed[17:9], mission_done[18], queue_full[19], zero
  output logic [23:0] m_tdata,
  // motor_write[0]
  output logic [0:0]  m_tuser,
  output logic        m_tlast,
  input  logic        cfg_wen,
  input  logic        cfg_addr,
  input  logic [9:0]  cfg_wdata
);

  logic                   in_valid;
  wms_pkg::item_t         item;
  logic                   fire;
  logic                   can_load;
  logic                   accept;

  logic [7:0]             tolerance;
  logic [9:0]             clamp;

  wms_pkg::queue_status_t qstat;
  wms_pkg::entry_t        head;
  wms_pkg::entry_t        push_entry;
  logic                   push;
  logic                   pop;

  wms_pkg::result_t       res0, res1, out_res;
  logic                   two;

  // process the held item once the result buffer has room for two beats
  assign fire     = in_valid && can_load;
  assign s_tready = !in_valid || fire;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (accept) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  // capture the operand beat
  always_ff @(posedge clk) begin
    if (accept) begin
      item.command     <= wms_pkg::cmd_e'(s_tuser);
      item.left_count  <= s_tdata[31:0];
      item.right_count <= s_tdata[63:32];
      item.move_amount <= s_tdata[79:64];
      item.move_speed  <= s_tdata[87:80];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= wms_pkg::TOLERANCE_RESET;
      clamp     <= wms_pkg::CLAMP_RESET;
    end else if (cfg_wen) begin
      case (cfg_addr)
        wms_pkg::CFG_TOLERANCE: tolerance <= cfg_wdata[7:0];
        wms_pkg::CFG_CLAMP:     clamp     <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  wms_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .status    (qstat),
    .head      (head)
  );

  wms_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (item),
    .tolerance (tolerance),
    .clamp     (clamp),
    .qstat     (qstat),
    .head      (head),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .res0      (res0),
    .res1      (res1),
    .two       (two)
  );

  wms_outbuf u_outbuf (
    .clk      (clk),
    .rst      (rst),
    .load     (fire),
    .two      (two),
    .res0     (res0),
    .res1     (res1),
    .out_ready(m_tready),
    .out_valid(m_tvalid),
    .out_res  (out_res),
    .can_load (can_load)
  );

  // pack the result beat
  assign m_tdata = {4'd0, out_res.queue_full, out_res.mission_done,
                    out_res.right_speed, out_res.left_speed};
  assign m_tuser = out_res.motor_write;
  assign m_tlast = out_res.last;

endmodule
